FILE: rtl/sist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sist_pkg: shared types and codes for the sorted integer set table
// Request and response payloads, command and status codes, and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package sist_pkg;

    localparam int CMD_W            = 2;
    localparam int VALUE_W          = 32;
    localparam int STATUS_W         = 3;
    localparam int COUNT_W          = 7;
    localparam int DEFAULT_CAPACITY = 64;

    // Command codes (the unused code behaves as a query)
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_ADDED    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXISTS   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_REMOVED  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_PRESENT  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT   = 3'd5;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd6;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] value;
    } req_data_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } rsp_data_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;  // register the compare row for the incoming request
        logic commit;   // apply the shift and load the response register
    } dp_cmd_t;

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } ctrl_state_t;

endpackage
`default_nettype wire

FILE: rtl/sorted_integer_set_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_integer_set_table: ordered set of distinct signed 32-bit integers
// Insert, remove and membership query over a sorted store of CAPACITY
// entries; one response (status and count) for every request.
// ----------------------------------------------------------------------------
// A request passes through the idle and update states: in the cycle it is
// accepted every entry is compared with its value in a row of compare cells
// and the result is registered; in the update state the entries at or above
// the found position shift by one place for an insert or a remove and the
// response register and valid flag are loaded. A new request is taken only
// in the idle state, after the last one is updated. A pending response does
// not block the next request, which waits in its update state only while the
// earlier response is not yet taken. No clearing pass is needed after reset.
module sorted_integer_set_table #(
    parameter int CAPACITY = sist_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire sist_pkg::req_data_t req_data,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output sist_pkg::rsp_data_t      rsp_data
);
    import sist_pkg::*;

    dp_cmd_t dp_cmd;

    // Sequencer
    sist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .dp_cmd    (dp_cmd)
    );

    // Compare row and entry store
    sist_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .dp_cmd   (dp_cmd),
        .req_data (req_data),
        .rsp_data (rsp_data)
    );

endmodule
`default_nettype wire

FILE: rtl/sist_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sist_ctrl: request sequencer
// Takes a request, runs the compare cycle and the update cycle, and owns
// the response valid flag.
// ----------------------------------------------------------------------------
module sist_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output sist_pkg::dp_cmd_t     dp_cmd
);
    import sist_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        rsp_valid_reg, rsp_valid_next;

    // State and response flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        dp_cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next     = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                // wait here while an earlier response is still held
                if (!rsp_valid_reg || rsp_ready)
                begin
                    dp_cmd.commit  = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

    // Commit only follows a capture
    a_commit_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.commit |-> (state_reg == S_UPDATE))
        else $error("commit outside update state");

    a_capture_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.capture |=> (state_reg == S_UPDATE))
        else $error("capture not followed by update state");

    a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.commit |=> rsp_valid)
        else $error("commit did not raise response valid");

endmodule
`default_nettype wire

FILE: rtl/sist_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sist_datapath: compare row and shifting entry store
// One cell per entry compares against the request value; the registered
// less-than row then drives each cell's shift for insert or remove.
// ----------------------------------------------------------------------------
module sist_datapath #(
    parameter int CAPACITY = sist_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sist_pkg::dp_cmd_t   dp_cmd,
    input  wire sist_pkg::req_data_t req_data,
    output sist_pkg::rsp_data_t      rsp_data
);
    import sist_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [VALUE_W-1:0] entries_reg  [CAPACITY];
    logic signed [VALUE_W-1:0] entries_next [CAPACITY];
    logic signed [VALUE_W-1:0] ins_src      [CAPACITY];
    logic signed [VALUE_W-1:0] rem_src      [CAPACITY];

    logic [CW-1:0]             count_reg, count_next;
    logic [CAPACITY-1:0]       lt_next, eq_next, lt_reg;
    logic                      hit_reg;
    logic [CMD_W-1:0]          cmd_reg;
    logic signed [VALUE_W-1:0] value_reg;
    rsp_data_t                 rsp_data_reg;

    logic                      full;
    logic                      do_ins, do_rem;
    logic [STATUS_W-1:0]       status_next;

    // Compare row and per-cell shift sources
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic in_range;
        assign in_range   = (CW'(i) < count_reg);
        assign lt_next[i] = in_range && (entries_reg[i] < req_data.value);
        assign eq_next[i] = in_range && (entries_reg[i] == req_data.value);

        if (i == 0)
        begin : g_ins_first
            assign ins_src[i] = value_reg;
        end
        else
        begin : g_ins_rest
            assign ins_src[i] = lt_reg[i-1] ? value_reg : entries_reg[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_rem_last
            assign rem_src[i] = entries_reg[i];
        end
        else
        begin : g_rem_rest
            assign rem_src[i] = entries_reg[i+1];
        end

        // cells at or above the insert/remove position move
        assign entries_next[i] = (do_ins && !lt_reg[i]) ? ins_src[i] :
                                 (do_rem && !lt_reg[i]) ? rem_src[i] :
                                 entries_reg[i];
    end

    // Decision for the captured request
    assign full   = (count_reg == CW'(CAPACITY));
    assign do_ins = dp_cmd.commit && (cmd_reg == CMD_INSERT) && !hit_reg && !full;
    assign do_rem = dp_cmd.commit && (cmd_reg == CMD_REMOVE) && hit_reg;

    always_comb
    begin
        case (cmd_reg)
            CMD_INSERT:
                status_next = hit_reg ? STATUS_EXISTS :
                              full    ? STATUS_FULL   : STATUS_ADDED;
            CMD_REMOVE:
                status_next = hit_reg ? STATUS_REMOVED : STATUS_NOTFOUND;
            CMD_QUERY:
                status_next = hit_reg ? STATUS_PRESENT : STATUS_ABSENT;
            default:
                status_next = hit_reg ? STATUS_PRESENT : STATUS_ABSENT;
        endcase
    end

    always_comb
    begin
        if (do_ins)
            count_next = count_reg + 1'b1;
        else if (do_rem)
            count_next = count_reg - 1'b1;
        else
            count_next = count_reg;
    end

    // Element count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Captured request and compare row
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            lt_reg    <= lt_next;
            hit_reg   <= |eq_next;
            cmd_reg   <= req_data.command;
            value_reg <= req_data.value;
        end
    end

    // Entry store and response register
    always_ff @(posedge clk)
    begin
        if (dp_cmd.commit)
        begin
            for (int k = 0; k < CAPACITY; k++)
                entries_reg[k] <= entries_next[k];
            rsp_data_reg.status <= status_next;
            rsp_data_reg.count  <= COUNT_W'(count_next);
        end
    end

    assign rsp_data = rsp_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("count above capacity");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow count");

    a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_rem |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("remove did not shrink count");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!do_ins && !do_rem) |=> $stable(count_reg))
        else $error("count changed without update");

    // sorted store gives a less-than row that is a run of ones from cell 0
    a_lt_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.capture |=> ((lt_reg & (lt_reg + 1'b1)) == '0))
        else $error("compare row not contiguous, store out of order");

endmodule
`default_nettype wire
